// ----- sv/assert_macros.svh -----
// assertion macros for the rtl files, included by dep_ctrl.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define DEP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define DEP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DEP_ASSERT(lbl, clk, rstn, prop, msg)

`define DEP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- sv/dep_pkg.sv -----
// shared types and constants of the double-ended priority queue
package dep_pkg;

  localparam int CAPACITY  = 16;
  localparam int PRIO_BITS = 32;
  localparam int DATA_BITS = 32;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int OP_BITS   = 3;
  localparam int ST_BITS   = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT  = 3'd0,
    OP_TAKE_HI = 3'd1,
    OP_TAKE_LO = 3'd2,
    OP_PEEK_HI = 3'd3,
    OP_PEEK_LO = 3'd4,
    OP_CLEAR   = 3'd5
  } op_e;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [PRIO_BITS-1:0] prio;
    logic [DATA_BITS-1:0]        data;
  } entry_t;

  typedef struct packed {
    logic                ins;
    logic                shift;
    entry_t              entry;
    logic [CNT_BITS-1:0] count;
  } cmd_t;

endpackage

// ----- sv/double_ended_priority_queue.sv -----
// top level of the double-ended priority queue built as a chain of sorted cells
//
// usage:
//   command channel: present opcode_i, prio_in_i and data_in_i with start high;
//   the beat is taken at any rising edge with start high and busy low. busy is
//   always low, so a new command may be issued every cycle.
//   result channel: done_o is high for one cycle, in the cycle after the command
//   was taken, with status_o, prio_out_o, data_out_o, occupancy_o and removed_o.
//   throughput is one command per cycle.
//   every cell compares against the new priority at once, so an insert or a
//   take of the lowest entry shifts the whole chain in the cycle it is taken; the
//   highest entry comes from a select over the cells by the fill count.
//   the receiver cannot stall: each result beat lasts exactly one cycle.
//   reset clears the fill count and the result strobe; cell contents are not
//   cleared, since only cells below the fill count are ever read.
module double_ended_priority_queue (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [dep_pkg::OP_BITS-1:0]          opcode_i,
  input  logic signed [dep_pkg::PRIO_BITS-1:0] prio_in_i,
  input  logic [dep_pkg::DATA_BITS-1:0]        data_in_i,
  output logic                                 done_o,
  output logic [dep_pkg::ST_BITS-1:0]          status_o,
  output logic signed [dep_pkg::PRIO_BITS-1:0] prio_out_o,
  output logic [dep_pkg::DATA_BITS-1:0]        data_out_o,
  output logic [dep_pkg::CNT_BITS-1:0]         occupancy_o,
  output logic [dep_pkg::CNT_BITS-1:0]         removed_o
);

  dep_pkg::cmd_t                          cmd;
  dep_pkg::entry_t [dep_pkg::CAPACITY-1:0] cells;
  logic [dep_pkg::CAPACITY-1:0]           ge;
  logic [dep_pkg::CAPACITY-1:0]           occ;
  logic                                   accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .opcode_i    (opcode_i),
    .prio_in_i   (prio_in_i),
    .data_in_i   (data_in_i),
    .cells_i     (cells),
    .cmd_o       (cmd),
    .done_o      (done_o),
    .status_o    (status_o),
    .prio_out_o  (prio_out_o),
    .data_out_o  (data_out_o),
    .occupancy_o (occupancy_o),
    .removed_o   (removed_o)
  );

  for (genvar g = 0; g < dep_pkg::CAPACITY; g++) begin : g_cell
    dep_pkg::entry_t left, right;
    logic            left_ge;

    assign occ[g] = (cmd.count > dep_pkg::CNT_BITS'(g));

    if (g == 0) begin : g_first
      assign left    = '0;
      assign left_ge = 1'b0;
    end else begin : g_inner
      assign left    = cells[g-1];
      assign left_ge = ge[g-1];
    end

    if (g == dep_pkg::CAPACITY - 1) begin : g_last
      assign right = cells[g];
    end else begin : g_mid
      assign right = cells[g+1];
    end

    dep_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .occ_i     (occ[g]),
      .left_ge_i (left_ge),
      .left_i    (left),
      .right_i   (right),
      .ge_o      (ge[g]),
      .entry_o   (cells[g])
    );
  end

endmodule

// ----- sv/dep_cell.sv -----
// one cell of the sorted chain: holds one entry and trades with its neighbours
module dep_cell (
  input  logic          clk_i,
  input  dep_pkg::cmd_t cmd_i,
  input  logic          occ_i,
  input  logic          left_ge_i,
  input  dep_pkg::entry_t left_i,
  input  dep_pkg::entry_t right_i,
  output logic          ge_o,
  output dep_pkg::entry_t entry_o
);

  dep_pkg::entry_t entry_q, entry_d;

  // true when the new entry belongs at or below this cell
  assign ge_o = !(occ_i && (entry_q.prio < cmd_i.entry.prio));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (left_ge_i) begin
        entry_d = left_i;
      end else if (ge_o) begin
        entry_d = cmd_i.entry;
      end
    end else if (cmd_i.shift) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins || cmd_i.shift) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ----- sv/dep_ctrl.sv -----
// fill count, command decode and result register of the queue
`include "assert_macros.svh"

module dep_ctrl (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [dep_pkg::OP_BITS-1:0]            opcode_i,
  input  logic signed [dep_pkg::PRIO_BITS-1:0]   prio_in_i,
  input  logic [dep_pkg::DATA_BITS-1:0]          data_in_i,
  input  dep_pkg::entry_t [dep_pkg::CAPACITY-1:0] cells_i,
  output dep_pkg::cmd_t                          cmd_o,
  output logic                                   done_o,
  output logic [dep_pkg::ST_BITS-1:0]            status_o,
  output logic signed [dep_pkg::PRIO_BITS-1:0]   prio_out_o,
  output logic [dep_pkg::DATA_BITS-1:0]          data_out_o,
  output logic [dep_pkg::CNT_BITS-1:0]           occupancy_o,
  output logic [dep_pkg::CNT_BITS-1:0]           removed_o
);

  logic [dep_pkg::CNT_BITS-1:0] count_q, count_d;
  logic                         done_q;
  dep_pkg::status_e             status_q, status_d;
  dep_pkg::entry_t              res_q, res_d;
  logic [dep_pkg::CNT_BITS-1:0] removed_q, removed_d;
  logic [dep_pkg::CNT_BITS-1:0] top_cnt;
  logic [dep_pkg::IDX_BITS-1:0] top_idx;
  logic                         empty, full;
  dep_pkg::cmd_t                cmd;

  assign empty   = (count_q == '0);
  assign full    = (count_q == dep_pkg::CNT_BITS'(dep_pkg::CAPACITY));
  assign top_cnt = count_q - dep_pkg::CNT_BITS'(1);
  assign top_idx = top_cnt[dep_pkg::IDX_BITS-1:0];

  always_comb begin
    cmd.ins        = 1'b0;
    cmd.shift      = 1'b0;
    cmd.entry.prio = prio_in_i;
    cmd.entry.data = data_in_i;
    cmd.count      = count_q;
    count_d        = count_q;
    status_d       = dep_pkg::ST_OK;
    res_d          = '0;
    removed_d      = '0;
    if (start_i) begin
      case (dep_pkg::op_e'(opcode_i))
        dep_pkg::OP_INSERT: begin
          if (full) begin
            status_d = dep_pkg::ST_FULL;
          end else begin
            cmd.ins = 1'b1;
            count_d = count_q + dep_pkg::CNT_BITS'(1);
          end
        end
        dep_pkg::OP_TAKE_HI, dep_pkg::OP_PEEK_HI: begin
          if (empty) begin
            status_d = dep_pkg::ST_EMPTY;
          end else begin
            res_d = cells_i[top_idx];
            if (opcode_i == dep_pkg::OP_TAKE_HI) begin
              count_d = top_cnt;
            end
          end
        end
        dep_pkg::OP_TAKE_LO, dep_pkg::OP_PEEK_LO: begin
          if (empty) begin
            status_d = dep_pkg::ST_EMPTY;
          end else begin
            res_d = cells_i[0];
            if (opcode_i == dep_pkg::OP_TAKE_LO) begin
              cmd.shift = 1'b1;
              count_d   = top_cnt;
            end
          end
        end
        dep_pkg::OP_CLEAR: begin
          removed_d = count_q;
          count_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      status_q  <= status_d;
      res_q     <= res_d;
      removed_q <= removed_d;
    end
  end

  assign cmd_o       = cmd;
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign prio_out_o  = res_q.prio;
  assign data_out_o  = res_q.data;
  assign occupancy_o = count_q;
  assign removed_o   = removed_q;

  `DEP_ASSERT(a_count_bound, clk_i, rst_ni,
    count_q <= dep_pkg::CNT_BITS'(dep_pkg::CAPACITY), "fill count beyond capacity")
  `DEP_ASSERT(a_done_follows, clk_i, rst_ni, start_i |=> done_q, "result beat missing")
  `DEP_ASSERT(a_insert_grows, clk_i, rst_ni,
    (start_i && opcode_i == dep_pkg::OP_INSERT && !full) |=>
    (count_q == $past(count_q) + dep_pkg::CNT_BITS'(1)), "insert did not grow count")
  `DEP_ASSERT(a_clear_empties, clk_i, rst_ni,
    (start_i && opcode_i == dep_pkg::OP_CLEAR) |=> (count_q == '0), "clear left entries")
  `DEP_ASSERT(a_full_only_full, clk_i, rst_ni,
    (done_q && status_q == dep_pkg::ST_FULL) |-> full, "full status with room left")

endmodule
